>>> rtl/core/lsrf_pkg.sv
package lsrf_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int SLOT_BYTES_DEF = 128;

    localparam int REQ_W    = 3;
    localparam int OFFSET_W = 6;
    localparam int POS_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int PEND_W   = 7;
    localparam int LEN_W    = 8;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COMMIT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CONSUME = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]    op;
        logic                known;
        logic                pos_ok;
        logic [OFFSET_W-1:0] line_offset;
        logic [POS_W-1:0]    byte_pos;
        logic [BYTE_W-1:0]   byte_value;
        logic [COUNT_W-1:0]  retire_count;
    } req_t;

endpackage

>>> rtl/core/line_slot_ring_fifo_unit.sv
// channel  direction  handshake             fields
// in       input      in_valid / in_ready   req_type line_offset byte_pos byte_value retire_count
// out      output     out_valid / out_ready ok is_full pending_lines line_length data_byte
//
// write byte, consume, unknown requests and a commit refused when full: finished in the idle state, result registered
// peek and read byte, refused or not: finished in the READ state, after the registered read of the slot memories
// commit: scans the line byte by byte through the SCAN and CHK states, up to SLOT_BYTES bytes, one memory read per byte
// a two-item queue takes new items while the back end works or a result waits
// rst_n clears the counters and handshake state; slot memories hold no reset value
module line_slot_ring_fifo_unit #(
    parameter int SLOTS      = lsrf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = lsrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lsrf_pkg::REQ_W-1:0]     req_type,
    input  logic [lsrf_pkg::OFFSET_W-1:0]  line_offset,
    input  logic [lsrf_pkg::POS_W-1:0]     byte_pos,
    input  logic [lsrf_pkg::BYTE_W-1:0]    byte_value,
    input  logic [lsrf_pkg::COUNT_W-1:0]   retire_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic                           is_full,
    output logic [lsrf_pkg::PEND_W-1:0]    pending_lines,
    output logic [lsrf_pkg::LEN_W-1:0]     line_length,
    output logic [lsrf_pkg::BYTE_W-1:0]    data_byte
);
    import lsrf_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_item;

    lsrf_front #(
        .SLOT_BYTES(SLOT_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .line_offset (line_offset),
        .byte_pos    (byte_pos),
        .byte_value  (byte_value),
        .retire_count(retire_count),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lsrf_back #(
        .SLOTS     (SLOTS),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ok           (ok),
        .is_full      (is_full),
        .pending_lines(pending_lines),
        .line_length  (line_length),
        .data_byte    (data_byte)
    );

endmodule

>>> rtl/core/lsrf_front.sv
module lsrf_front #(
    parameter int SLOT_BYTES = lsrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lsrf_pkg::REQ_W-1:0]     req_type,
    input  logic [lsrf_pkg::OFFSET_W-1:0]  line_offset,
    input  logic [lsrf_pkg::POS_W-1:0]     byte_pos,
    input  logic [lsrf_pkg::BYTE_W-1:0]    byte_value,
    input  logic [lsrf_pkg::COUNT_W-1:0]   retire_count,
    output logic                           q_valid,
    output lsrf_pkg::req_t                 q_item,
    input  logic                           q_pop
);
    import lsrf_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       item;
    logic       push;

    // classify the item
    always_comb
    begin
        item.op           = req_type;
        item.known        = (req_type == REQ_WRITE) || (req_type == REQ_COMMIT) ||
                            (req_type == REQ_PEEK) || (req_type == REQ_READ) ||
                            (req_type == REQ_CONSUME);
        item.pos_ok       = (32'(byte_pos) < SLOT_BYTES);
        item.line_offset  = line_offset;
        item.byte_pos     = byte_pos;
        item.byte_value   = byte_value;
        item.retire_count = retire_count;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

>>> rtl/core/lsrf_back.sv
module lsrf_back #(
    parameter int SLOTS      = lsrf_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = lsrf_pkg::SLOT_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  lsrf_pkg::req_t               q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         ok,
    output logic                         is_full,
    output logic [lsrf_pkg::PEND_W-1:0]  pending_lines,
    output logic [lsrf_pkg::LEN_W-1:0]   line_length,
    output logic [lsrf_pkg::BYTE_W-1:0]  data_byte
);
    import lsrf_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int CW   = SW + 1;
    localparam int AW   = $clog2(SLOTS * SLOT_BYTES);
    localparam int BW   = $clog2(SLOT_BYTES + 1);
    localparam int BPW  = $clog2(SLOT_BYTES);
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_CHK  = 2'd3;

    logic [BYTE_W-1:0] line_mem [SLOTS*SLOT_BYTES];
    logic [BW-1:0]     len_mem  [SLOTS];

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     head_reg, head_next;
    logic [CW-1:0]     tail_reg, tail_next;
    logic [BW-1:0]     scan_reg, scan_next;
    req_t              cur_reg;
    logic              hit_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BW-1:0]     len_rd_reg;

    logic              out_valid_reg;
    logic              ok_reg;
    logic              full_reg;
    logic [PEND_W-1:0] pend_out_reg;
    logic [LEN_W-1:0]  len_out_reg;
    logic [BYTE_W-1:0] data_out_reg;

    logic [CW-1:0]     pend, pend_post;
    logic              full;
    logic [SW-1:0]     head_slot, rd_slot;
    logic [AW-1:0]     head_base, rd_addr, wr_addr;
    logic              wr_en, len_we, hit;
    logic [BW-1:0]     len_wdata;
    logic [CMPW-1:0]   retire_n;
    logic              fin;
    logic              fin_ok;
    logic [LEN_W-1:0]  fin_len;
    logic [BYTE_W-1:0] fin_data;

    assign pend      = head_reg - tail_reg;
    assign full      = (pend == CW'(SLOTS));
    assign head_slot = head_reg[SW-1:0];
    assign rd_slot   = tail_reg[SW-1:0] + SW'(q_item.line_offset);
    assign head_base = AW'(head_slot) * AW'(SLOT_BYTES);
    assign wr_addr   = head_base + AW'(BPW'(q_item.byte_pos));
    assign hit       = (CMPW'(q_item.line_offset) < CMPW'(pend));
    assign retire_n  = (CMPW'(q_item.retire_count) < CMPW'(pend)) ?
                       CMPW'(q_item.retire_count) : CMPW'(pend);
    assign pend_post = head_next - tail_next;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        scan_next  = scan_reg;
        rd_addr    = AW'(rd_slot) * AW'(SLOT_BYTES) + AW'(BPW'(q_item.byte_pos));
        wr_en      = 1'b0;
        len_we     = 1'b0;
        len_wdata  = scan_reg;
        fin        = 1'b0;
        fin_ok     = 1'b0;
        fin_len    = '0;
        fin_data   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    priority if (!q_item.known)
                    begin
                        fin = 1'b1;
                    end
                    else if (q_item.op == REQ_WRITE)
                    begin
                        fin    = 1'b1;
                        fin_ok = !full && q_item.pos_ok;
                        wr_en  = fin_ok;
                    end
                    else if (q_item.op == REQ_COMMIT)
                    begin
                        if (full)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (q_item.op == REQ_CONSUME)
                    begin
                        fin       = 1'b1;
                        fin_ok    = 1'b1;
                        tail_next = tail_reg + CW'(retire_n);
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                fin    = 1'b1;
                fin_ok = hit_reg && ((cur_reg.op == REQ_PEEK) || cur_reg.pos_ok);
                if (fin_ok)
                begin
                    fin_len = LEN_W'(len_rd_reg);
                end
                if (fin_ok && (cur_reg.op == REQ_READ))
                begin
                    fin_data = rd_data_reg;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                rd_addr    = head_base + AW'(scan_reg);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                priority if (rd_data_reg == '0)
                begin
                    len_wdata = scan_reg;
                    len_we    = 1'b1;
                end
                else if (scan_reg + BW'(1) == BW'(SLOT_BYTES))
                begin
                    len_wdata = BW'(SLOT_BYTES);
                    len_we    = 1'b1;
                end
                else
                begin
                    scan_next  = scan_reg + BW'(1);
                    state_next = ST_SCAN;
                end
                if (len_we)
                begin
                    head_next  = head_reg + CW'(1);
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        rd_data_reg <= line_mem[rd_addr];
        len_rd_reg  <= len_mem[rd_slot];
        if (q_pop)
        begin
            cur_reg <= q_item;
            hit_reg <= hit;
        end
        if (wr_en)
        begin
            line_mem[wr_addr] <= q_item.byte_value;
        end
        if (len_we)
        begin
            len_mem[head_slot] <= len_wdata;
        end
        if (fin)
        begin
            ok_reg       <= fin_ok;
            full_reg     <= (pend_post == CW'(SLOTS));
            pend_out_reg <= PEND_W'(pend_post);
            len_out_reg  <= fin_len;
            data_out_reg <= fin_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign is_full       = full_reg;
    assign pending_lines = pend_out_reg;
    assign line_length   = len_out_reg;
    assign data_byte     = data_out_reg;

endmodule

>>> rtl/core/lsrf_checker.sv
module lsrf_checker #(
    parameter int SLOTS = lsrf_pkg::SLOTS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           ok,
    input logic                           is_full,
    input logic [lsrf_pkg::PEND_W-1:0]    pending_lines,
    input logic [lsrf_pkg::LEN_W-1:0]     line_length,
    input logic [lsrf_pkg::BYTE_W-1:0]    data_byte
);
    import lsrf_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(pending_lines))
        else $error("result changed while stalled");

    a_full_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_full |-> pending_lines == PEND_W'(SLOTS))
        else $error("full flag without full ring");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_byte != '0 |-> ok)
        else $error("data byte on refused item");

    a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_length != '0 |-> ok)
        else $error("line length on refused item");

endmodule

bind line_slot_ring_fifo_unit lsrf_checker #(.SLOTS(SLOTS)) u_lsrf_checker (.*);
